/* sv/olist_pkg.sv */
// Shared types and constants for the ordered value list engine.
package olist_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_LIST   = 3'd1,
        OP_SEARCH = 3'd2,
        OP_MODIFY = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

/* sv/ordered_value_list_engine.sv */
// Top level of the ordered value list engine: request sequencer and result register.
//
// Keeps up to DEPTH signed 32-bit values in append order in a RAM with a registered read port.
// Request channel: i_valid / o_ready with i_opcode, i_key, i_new_value.
// Result channel: o_valid / i_ready with o_status, o_value, o_position, o_last.
// Append, and any other request that meets an empty list, is answered from
// the count alone: one result, registered as the request is taken.
// List, search, modify and delete walk the RAM from entry 0, one read per
// cycle on its single read port while the result register is free, and list
// gives one result per stored value per cycle while the receiver takes them.
// Delete closes the gap in the same walk, writing each later value one place
// down through the write port. The next request is taken once the walk ends.
// Opcodes above delete are taken and dropped with no result.
// Reset empties the list; stored values are not cleared.
// When the receiver stalls, the walk pauses with the result register full;
// no read is issued and nothing is lost.
module ordered_value_list_engine import olist_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [VAL_W-1:0] i_key,
    input  logic signed [VAL_W-1:0] i_new_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_value,
    output logic [POS_W-1:0]        o_position,
    output logic                    o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Control state
    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_pend, n_pend;
    logic          r_found, n_found;
    logic [AW-1:0] r_idx, n_idx;
    logic [VAL_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_nv, n_nv;

    // Result register
    logic             r_out_valid, n_out_valid;
    t_status          r_status;
    logic [VAL_W-1:0] r_value;
    logic [POS_W-1:0] r_pos;
    logic             r_last;

    // RAM and result load controls
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;
    logic             ld;
    t_status          ld_status;
    logic [VAL_W-1:0] ld_value;
    logic [POS_W-1:0] ld_pos;
    logic             ld_last;
    logic             out_free, is_end, hit, done;

    olist_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign is_end   = (CW'(r_cur) == (r_count - CW'(1)));
    assign hit      = (ram_rdata == r_key);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_count   = r_count;
        n_rd_addr = r_rd_addr;
        n_cur     = r_cur;
        n_pend    = r_pend;
        n_found   = r_found;
        n_idx     = r_idx;
        n_key     = r_key;
        n_nv      = r_nv;
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = r_nv;
        ram_re    = 1'b0;
        ram_raddr = r_rd_addr[AW-1:0];
        ld        = 1'b0;
        ld_status = ST_OK;
        ld_value  = '0;
        ld_pos    = '0;
        ld_last   = 1'b1;
        done      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && out_free) begin
                    case (i_opcode)
                        OP_APPEND: begin
                            ld = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                ld_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_key;
                                ld_pos    = POS_W'(r_count);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_LIST, OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                            if (r_count == '0) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                n_state   = S_SCAN;
                                n_op      = t_op'(i_opcode);
                                n_key     = i_key;
                                n_nv      = i_new_value;
                                n_rd_addr = '0;
                                n_pend    = 1'b0;
                                n_found   = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    // issue the next read
                    if (r_rd_addr < r_count) begin
                        ram_re    = 1'b1;
                        n_cur     = r_rd_addr[AW-1:0];
                        n_rd_addr = r_rd_addr + CW'(1);
                    end
                    n_pend = (r_rd_addr < r_count);

                    // evaluate the entry returned by the last issued read
                    if (r_pend) begin
                        case (r_op)
                            OP_LIST: begin
                                ld       = 1'b1;
                                ld_value = ram_rdata;
                                ld_pos   = POS_W'(r_cur);
                                ld_last  = is_end;
                                done     = is_end;
                            end
                            OP_SEARCH: begin
                                if (hit) begin
                                    ld       = 1'b1;
                                    ld_value = ram_rdata;
                                    ld_pos   = POS_W'(r_cur);
                                    done     = 1'b1;
                                end else if (is_end) begin
                                    ld        = 1'b1;
                                    ld_status = ST_NOTFOUND;
                                    done      = 1'b1;
                                end
                            end
                            OP_MODIFY: begin
                                if (hit) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_cur;
                                    ram_wdata = r_nv;
                                    ld        = 1'b1;
                                    ld_pos    = POS_W'(r_cur);
                                    done      = 1'b1;
                                end else if (is_end) begin
                                    ld        = 1'b1;
                                    ld_status = ST_NOTFOUND;
                                    done      = 1'b1;
                                end
                            end
                            OP_DELETE: begin
                                if (r_found) begin
                                    // close the gap: move this value down one place
                                    ram_we    = 1'b1;
                                    ram_waddr = r_cur - AW'(1);
                                    ram_wdata = ram_rdata;
                                    if (is_end) begin
                                        ld      = 1'b1;
                                        ld_pos  = POS_W'(r_idx);
                                        n_count = r_count - CW'(1);
                                        done    = 1'b1;
                                    end
                                end else if (hit) begin
                                    n_found = 1'b1;
                                    n_idx   = r_cur;
                                    if (is_end) begin
                                        ld      = 1'b1;
                                        ld_pos  = POS_W'(r_cur);
                                        n_count = r_count - CW'(1);
                                        done    = 1'b1;
                                    end
                                end else if (is_end) begin
                                    ld        = 1'b1;
                                    ld_status = ST_NOTFOUND;
                                    done      = 1'b1;
                                end
                            end
                            default: done = 1'b1;
                        endcase
                    end

                    if (done) begin
                        n_state = S_IDLE;
                        n_pend  = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result register valid
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (ld) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_op        <= OP_APPEND;
            r_rd_addr   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_rd_addr   <= n_rd_addr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_idx <= n_idx;
        r_key <= n_key;
        r_nv  <= n_nv;
        if (ld) begin
            r_status <= ld_status;
            r_value  <= ld_value;
            r_pos    <= ld_pos;
            r_last   <= ld_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_value    = r_value;
    assign o_position = r_pos;
    assign o_last     = r_last;

    // Count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above capacity");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)))
        else $error("list count jumped");

    // Walk reads stay inside the stored range
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_rd_addr < r_count))
        else $error("read past end of list");

    // Pending read data always belongs to a stored entry
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (CW'(r_cur) < r_count))
        else $error("pending entry outside list");

    // Walk writes only for modify or delete
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_SCAN) |-> (r_op == OP_MODIFY || r_op == OP_DELETE))
        else $error("unexpected entry write during walk");

endmodule

/* sv/olist_ram.sv */
// Entry store: one write port and one registered read port.
module olist_ram import olist_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/olist_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the ordered value list engine: mirrors the list and checks each result.
module olist_checker import olist_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request side
    input  logic                    i_req_valid,
    input  logic                    i_req_ready,
    input  logic [OP_W-1:0]         i_req_opcode,
    input  logic signed [VAL_W-1:0] i_req_key,
    input  logic signed [VAL_W-1:0] i_req_new_value,
    // result side
    input  logic                    i_rsp_valid,
    input  logic                    i_rsp_ready,
    input  logic [ST_W-1:0]         i_rsp_status,
    input  logic signed [VAL_W-1:0] i_rsp_value,
    input  logic [POS_W-1:0]        i_rsp_position,
    input  logic                    i_rsp_last,
    output int                      o_mismatches,
    output int                      o_pending
);

    typedef struct {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    last;
    } t_reply;

    // Results still owed by the block, oldest first
    t_reply replies_due[$];

    // Mirror of the stored list
    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int                      list_len;

    function automatic void queue_reply(t_status st, logic signed [VAL_W-1:0] v, int p,
                                        logic l);
        t_reply r;
        r.status   = st;
        r.value    = v;
        r.position = POS_W'(p);
        r.last     = l;
        replies_due.push_back(r);
    endfunction

    // Apply one request to the mirror and queue the results it owes
    task automatic predict_replies(input logic [OP_W-1:0] op,
                                   input logic signed [VAL_W-1:0] key,
                                   input logic signed [VAL_W-1:0] nv);
        int hit;
        int i;
        case (op)
            OP_APPEND: begin
                if (list_len >= DEPTH) begin
                    queue_reply(ST_FULL, '0, 0, 1'b1);
                end else begin
                    list_vals[list_len] = key;
                    queue_reply(ST_OK, '0, list_len, 1'b1);
                    list_len++;
                end
            end
            OP_LIST, OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                if (list_len == 0) begin
                    queue_reply(ST_EMPTY, '0, 0, 1'b1);
                end else if (op == OP_LIST) begin
                    for (i = 0; i < list_len; i++)
                        queue_reply(ST_OK, list_vals[i], i, i == list_len - 1);
                end else begin
                    // scan from the tail so the first match wins
                    hit = list_len;
                    for (i = list_len - 1; i >= 0; i--)
                        if (list_vals[i] == key) hit = i;
                    if (hit == list_len) begin
                        queue_reply(ST_NOTFOUND, '0, 0, 1'b1);
                    end else if (op == OP_SEARCH) begin
                        queue_reply(ST_OK, list_vals[hit], hit, 1'b1);
                    end else if (op == OP_MODIFY) begin
                        list_vals[hit] = nv;
                        queue_reply(ST_OK, '0, hit, 1'b1);
                    end else begin
                        // later values close up one place
                        for (i = hit; i < list_len - 1; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_len--;
                        queue_reply(ST_OK, '0, hit, 1'b1);
                    end
                end
            end
            default: ;  // spare opcodes are dropped without a result
        endcase
    endtask

    // Compare one delivered result against the oldest one owed
    task automatic check_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            $error("unexpected result: status %0d value %0d position %0d last %0b",
                   i_rsp_status, i_rsp_value, i_rsp_position, i_rsp_last);
            o_mismatches++;
        end else begin
            want = replies_due.pop_front();
            if (i_rsp_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_rsp_status);
                o_mismatches++;
            end
            if (i_rsp_value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, i_rsp_value);
                o_mismatches++;
            end
            if (i_rsp_position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, i_rsp_position);
                o_mismatches++;
            end
            if (i_rsp_last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, i_rsp_last);
                o_mismatches++;
            end
        end
    endtask

    // Handshakes are sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            replies_due.delete();
            list_len     = 0;
            o_mismatches = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) check_reply();
            if (i_req_valid && i_req_ready)
                predict_replies(i_req_opcode, i_req_key, i_req_new_value);
        end
        o_pending = replies_due.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top of the list engine testbench: clock, reset, request stimulus, result pacing, verdict.
module tb;
    import olist_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    // opcodes the block takes and drops
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    typedef enum int {MIX_GROW, MIX_CHURN, MIX_DRAIN} t_mix;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [OP_W-1:0]         i_opcode;
    logic signed [VAL_W-1:0] i_key;
    logic signed [VAL_W-1:0] i_new_value;
    logic                    o_valid;
    logic                    i_ready;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_value;
    logic [POS_W-1:0]        o_position;
    logic                    o_last;

    int mismatches;
    int pending;
    bit steady;      // no idling on either side
    bit hold_req;    // ask the receiver for one long hold-off

    logic signed [VAL_W-1:0] key_pool [8];

    ordered_value_list_engine #(.DEPTH(LIST_DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    olist_checker #(.DEPTH(LIST_DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_opcode    (i_opcode),
        .i_req_key       (i_key),
        .i_req_new_value (i_new_value),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_rsp_status    (o_status),
        .i_rsp_value     (o_value),
        .i_rsp_position  (o_position),
        .i_rsp_last      (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL ordered_value_list_engine");
        $finish;
    end

    // Mostly keys that are likely stored, sometimes any 32-bit value
    function automatic logic signed [VAL_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Present one request after a random gap and hold it until taken; called at a falling edge
    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic signed [VAL_W-1:0] key,
                                 input logic signed [VAL_W-1:0] nv);
        int r;
        int gap;
        gap = 0;
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r < 60)      gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else             gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_key       <= key;
        i_new_value <= nv;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Result pacing: random stalls, one long hold-off on request
    initial begin : receiver
        int  stall_left;
        int  r;
        bit  held;
        i_ready    = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held       = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready    <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Request stimulus and verdict
    initial begin : stimulus
        int               served;
        int               episode;
        int               span;
        int               r;
        int               wait_cycles;
        t_mix             mix;
        logic [OP_W-1:0]  op;
        logic [OP_W-1:0]  spare;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = OP_APPEND;
        i_key       = '0;
        i_new_value = '0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        key_pool[0] = VAL_MIN;
        key_pool[1] = VAL_MAX;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int k = 4; k < 8; k++) key_pool[k] = $urandom();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every non-append request on an empty list
        offer_request(OP_SEARCH, VAL_MAX, '0);
        offer_request(OP_LIST, '0, '0);
        offer_request(OP_MODIFY, VAL_MIN, VAL_MAX);
        offer_request(OP_DELETE, -32'sd1, '0);
        // deleting the only element empties the list
        offer_request(OP_APPEND, VAL_MIN, '0);
        offer_request(OP_DELETE, VAL_MIN, '0);
        offer_request(OP_LIST, '0, '0);
        // extremes, with a duplicate to check first-match
        offer_request(OP_APPEND, VAL_MAX, '0);
        offer_request(OP_APPEND, '0, '0);
        offer_request(OP_APPEND, -32'sd1, '0);
        offer_request(OP_APPEND, VAL_MIN, '0);
        offer_request(OP_APPEND, VAL_MAX, '0);
        offer_request(OP_SEARCH, VAL_MAX, '0);
        offer_request(OP_SEARCH, 32'sd12345, '0);
        offer_request(OP_MODIFY, VAL_MAX, VAL_MIN);
        offer_request(OP_MODIFY, 32'sd777, VAL_MAX);
        offer_request(OP_DELETE, 32'sd4242, '0);
        offer_request(OP_DELETE, -32'sd1, '0);
        offer_request(OP_LIST, '0, '0);
        // spare opcodes give nothing
        offer_request(OP_RSVD_A, VAL_MIN, VAL_MAX);
        offer_request(OP_RSVD_B, VAL_MAX, VAL_MIN);
        offer_request(OP_RSVD_C, -32'sd1, -32'sd1);

        // Random episodes: a growing mix, then a draining mix, then mixed traffic
        served  = 0;
        episode = 0;
        while (served < 305) begin
            case (episode)
                0:       mix = MIX_GROW;
                1:       mix = MIX_DRAIN;
                default: mix = t_mix'($urandom_range(0, 2));
            endcase
            span = (episode == 0) ? 30 : $urandom_range(15, 40);
            steady <= (episode == 3);
            repeat (span) begin
                r     = $urandom_range(0, 99);
                spare = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
                case (mix)
                    MIX_GROW:
                        op = (r < 70) ? OP_APPEND : (r < 78) ? OP_LIST :
                             (r < 86) ? OP_SEARCH : (r < 92) ? OP_MODIFY :
                             (r < 97) ? OP_DELETE : spare;
                    MIX_CHURN:
                        op = (r < 30) ? OP_APPEND : (r < 45) ? OP_LIST :
                             (r < 65) ? OP_SEARCH : (r < 80) ? OP_MODIFY :
                             (r < 97) ? OP_DELETE : spare;
                    default:
                        op = (r < 8)  ? OP_APPEND : (r < 18) ? OP_LIST :
                             (r < 33) ? OP_SEARCH : (r < 43) ? OP_MODIFY :
                             (r < 98) ? OP_DELETE : spare;
                endcase
                offer_request(op, pick_key(), pick_key());
                if (op <= OP_DELETE) served++;
                // long receiver hold-off while requests keep coming
                if (served == 150) hold_req <= 1'b1;
            end
            episode++;
        end

        // Drain: wait for every owed result, then keep watching for stray results
        i_valid <= 1'b0;
        steady  <= 1'b1;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 50000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LIST_DEPTH + 8) @(negedge i_clk);
        if (pending != 0) $error("%0d results never arrived", pending);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS ordered_value_list_engine");
        end else begin
            $display("FAIL ordered_value_list_engine");
        end
        $finish;
    end

endmodule
